// ----- src/cdwg_pkg.sv -----
// Shared types, register map and sine table function for the coil drive waveform generator.
`timescale 1ns / 1ps

package cdwg_pkg;

    // Default sizes
    localparam int TABLE_MAX_DEF     = 100;
    localparam int PHASE_BITS_DEF    = 24;
    localparam int ROM_ADDR_BITS_DEF = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 29;

    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INTENSITY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SINE_LEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SINE_STEP = 3'd5;

    // Register widths
    localparam int MODE_W   = 2;
    localparam int STEP_W   = 29;
    localparam int PCT_W    = 7;
    localparam int LEN_W    = 7;
    localparam int SSTEP_W  = 22;
    localparam int DUTY_W   = 8;

    // Waveform codes
    localparam logic [MODE_W-1:0] MODE_SAW   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LAYER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SINE  = 2'd2;

    // Reset values
    localparam logic [PCT_W-1:0]   PCT_RST       = 7'd100;
    localparam logic [DUTY_W-1:0]  FULL_RST      = 8'd255;
    localparam logic [LEN_W-1:0]   SINE_LEN_RST  = 7'd8;
    localparam logic [SSTEP_W-1:0] SINE_STEP_RST = 22'd2097152;

    // full = floor(255 * pct / 100) as a multiply by a reciprocal
    localparam logic [PCT_W-1:0] PCT_MAX     = 7'd100;
    localparam logic [7:0]       FULL_SCALE  = 8'd255;
    localparam logic [12:0]      FULL_RECIP  = 13'd5243;
    localparam int               FULL_SHIFT  = 19;

    // Burst window is 60 ticks worth of phase
    localparam logic [5:0] BURST_MULT = 6'd60;

    // Sine table entries are Q30 fractions
    localparam int ROM_W = 31;

    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_SAW,
        KIND_LAYER,
        KIND_SINE
    } t_kind;

    // Q30 coefficients of sin(pi/2 * t)
    localparam logic [63:0] C1  = 64'd1686629713;
    localparam logic [63:0] C3  = 64'd693598700;
    localparam logic [63:0] C5  = 64'd85569308;
    localparam logic [63:0] C7  = 64'd5026990;
    localparam logic [63:0] C9  = 64'd172272;
    localparam logic [63:0] Q30 = 64'h4000_0000;

    // Quarter-wave sine sample for address a of a 2^rbits table
    function automatic logic [ROM_W-1:0] rom_value(input int unsigned a,
                                                   input int unsigned rbits);
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] y;
        t  = 64'(a) << (30 - rbits);
        t2 = (t * t) >> 30;
        y  = C7 - ((t2 * C9) >> 30);
        y  = C5 - ((t2 * y) >> 30);
        y  = C3 - ((t2 * y) >> 30);
        y  = C1 - ((t2 * y) >> 30);
        y  = (t * y) >> 30;
        if (y > Q30) begin
            y = Q30;
        end
        return y[ROM_W-1:0];
    endfunction

endpackage

// ----- src/coil_drive_waveform_generator_unit.sv -----
// Top level of the coil drive waveform generator: tick stream in, duty and polarity out.
`timescale 1ns / 1ps

// Each input item is one sample tick; each tick yields exactly one result item carrying an
// 8-bit magnitude duty, the coil polarity and a period-wrap flag. The block takes one item
// per clock cycle while the input side is not stalled and carries it through three
// registers: the first holds the updated phase state, the second the sine table read and
// the ramp product, the third (the output register) the sine product. Each stage carries
// its own valid bit, so bubbles close up and the input side stalls only once all three
// stages hold an item and the output side is holding off.
// Configuration registers are written over the cfg channel, which is always ready; write them
// only while no item is in flight. Waveforms: sawtooth (mode 0), layered burst (mode 1) and
// sign-magnitude sine (mode 2); mode 3 yields zero and holds the phase state (a restart
// still clears it).

module coil_drive_waveform_generator_unit #(
    parameter int TABLE_MAX     = cdwg_pkg::TABLE_MAX_DEF,
    parameter int PHASE_BITS    = cdwg_pkg::PHASE_BITS_DEF,
    parameter int ROM_ADDR_BITS = cdwg_pkg::ROM_ADDR_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [cdwg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cdwg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // tick items
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [0] restart, [7:1] zero
    // result items
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [15:0]                     m_axis_tdata   // [7:0] magnitude_duty,
                                                           // [8] polarity, [9] period_wrap
);

    localparam int PB       = PHASE_BITS;
    localparam int RB       = ROM_ADDR_BITS;
    localparam int SUM_W    = ((PB > cdwg_pkg::STEP_W) ? PB : cdwg_pkg::STEP_W) + 1;
    localparam int SSUM_W   = ((PB > cdwg_pkg::SSTEP_W) ? PB : cdwg_pkg::SSTEP_W) + 1;
    localparam int ROM_DEPTH = (1 << RB) + 1;
    localparam int BURST_W  = cdwg_pkg::STEP_W + 6;
    localparam logic [7:0] TMAX = 8'(TABLE_MAX);
    localparam logic [RB:0] ROM_TOP = (RB+1)'(1 << RB);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [cdwg_pkg::MODE_W-1:0]  r_mode;
    logic                         r_enable;
    logic [cdwg_pkg::STEP_W-1:0]  r_phase_step;
    logic [cdwg_pkg::DUTY_W-1:0]  r_full;
    logic [cdwg_pkg::LEN_W-1:0]   r_sine_len;
    logic [cdwg_pkg::SSTEP_W-1:0] r_sine_step;

    logic [cdwg_pkg::PCT_W-1:0]   w_pct;
    logic [14:0]                  w_pct_prod;
    logic [27:0]                  w_full_prod;
    logic [cdwg_pkg::DUTY_W-1:0]  n_full;

    assign o_cfg_ready = 1'b1;

    // Clamp intensity to 100 and fold it into the full-scale duty at write time
    always_comb begin
        w_pct       = (i_cfg_data[cdwg_pkg::PCT_W-1:0] > cdwg_pkg::PCT_MAX) ?
                      cdwg_pkg::PCT_MAX : i_cfg_data[cdwg_pkg::PCT_W-1:0];
        w_pct_prod  = 15'(cdwg_pkg::FULL_SCALE) * 15'(w_pct);
        w_full_prod = 28'(w_pct_prod) * 28'(cdwg_pkg::FULL_RECIP);
        n_full      = w_full_prod[cdwg_pkg::FULL_SHIFT +: cdwg_pkg::DUTY_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= cdwg_pkg::MODE_SAW;
            r_enable     <= 1'b0;
            r_phase_step <= '0;
            r_full       <= cdwg_pkg::FULL_RST;
            r_sine_len   <= cdwg_pkg::SINE_LEN_RST;
            r_sine_step  <= cdwg_pkg::SINE_STEP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                cdwg_pkg::REG_MODE:      r_mode       <= i_cfg_data[cdwg_pkg::MODE_W-1:0];
                cdwg_pkg::REG_ENABLE:    r_enable     <= i_cfg_data[0];
                cdwg_pkg::REG_PHASE:     r_phase_step <= i_cfg_data[cdwg_pkg::STEP_W-1:0];
                cdwg_pkg::REG_INTENSITY: r_full       <= n_full;
                cdwg_pkg::REG_SINE_LEN:  r_sine_len   <= i_cfg_data[cdwg_pkg::LEN_W-1:0];
                cdwg_pkg::REG_SINE_STEP: r_sine_step  <= i_cfg_data[cdwg_pkg::SSTEP_W-1:0];
                default: ;  // writes beyond the map are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: each stage advances when its successor frees up
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_vo;
    logic w_adv1, w_adv2, w_advo;
    logic w_accept;

    assign w_advo        = !r_vo || m_axis_tready;
    assign w_adv2        = !r_v2 || w_advo;
    assign w_adv1        = !r_v1 || w_adv2;
    assign s_axis_tready = w_adv1;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_adv1) begin
                r_v1 <= w_accept;
            end
            if (w_adv2) begin
                r_v2 <= r_v1;
            end
            if (w_advo) begin
                r_vo <= r_v2;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: phase state update on every accepted tick
    // ------------------------------------------------------------------
    logic [PB-1:0]               r_ramp;
    logic                        r_saw_pol;
    logic [cdwg_pkg::LEN_W-1:0]  r_sample_index;
    logic [PB-1:0]               r_sine_phase;

    logic [PB-1:0]               n_ramp;
    logic                        n_saw_pol;
    logic [cdwg_pkg::LEN_W-1:0]  n_sample_index;
    logic [PB-1:0]               n_sine_phase;

    logic [PB-1:0]               w_ramp0;
    logic                        w_saw0;
    logic [cdwg_pkg::LEN_W-1:0]  w_idx0;
    logic [PB-1:0]               w_sph0;
    logic [SUM_W-1:0]            w_sum;
    logic [SSUM_W-1:0]           w_ssum;
    logic [cdwg_pkg::LEN_W:0]    w_idx_inc;
    logic [cdwg_pkg::LEN_W-1:0]  w_len;
    logic [1:0]                  w_quad;

    cdwg_pkg::t_kind             n_kind;
    logic                        n_pol;
    logic                        n_wrap;
    logic [RB:0]                 n_addr;

    cdwg_pkg::t_kind             r_s1_kind;
    logic                        r_s1_pol;
    logic                        r_s1_wrap;
    logic [RB:0]                 r_s1_addr;
    logic [PB-1:0]               r_s1_ramp;

    always_comb begin
        // restart clears the phase state ahead of this tick
        w_ramp0   = s_axis_tdata[0] ? '0   : r_ramp;
        w_saw0    = s_axis_tdata[0] ? 1'b0 : r_saw_pol;
        w_idx0    = s_axis_tdata[0] ? '0   : r_sample_index;
        w_sph0    = s_axis_tdata[0] ? '0   : r_sine_phase;

        w_sum     = SUM_W'(w_ramp0) + SUM_W'(r_phase_step);
        w_ssum    = SSUM_W'(w_sph0) + SSUM_W'(r_sine_step);
        w_idx_inc = {1'b0, w_idx0} + 1'b1;
        w_len     = ({1'b0, r_sine_len} > TMAX) ? TMAX[cdwg_pkg::LEN_W-1:0] : r_sine_len;
        w_quad    = w_sph0[PB-1 -: 2];

        n_ramp         = w_ramp0;
        n_saw_pol      = w_saw0;
        n_sample_index = w_idx0;
        n_sine_phase   = w_sph0;
        n_kind         = cdwg_pkg::KIND_ZERO;
        n_pol          = 1'b0;
        n_wrap         = 1'b0;
        n_addr         = '0;

        if (!r_enable) begin
            n_ramp         = '0;
            n_sample_index = '0;
            n_sine_phase   = '0;
        end else begin
            case (r_mode)
                cdwg_pkg::MODE_SAW, cdwg_pkg::MODE_LAYER: begin
                    n_wrap         = (w_sum[SUM_W-1:PB] != '0);
                    n_ramp         = w_sum[PB-1:0];
                    n_sample_index = '0;
                    n_sine_phase   = '0;
                    if (r_mode == cdwg_pkg::MODE_SAW) begin
                        n_saw_pol = w_saw0 ^ n_wrap;
                        n_pol     = n_saw_pol;
                        n_kind    = cdwg_pkg::KIND_SAW;
                    end else begin
                        n_kind    = cdwg_pkg::KIND_LAYER;
                    end
                end
                cdwg_pkg::MODE_SINE: begin
                    n_ramp = '0;
                    if (w_len != '0) begin
                        // quarter address from the bits under the quadrant, mirrored
                        // in the falling quadrants
                        n_addr = {1'b0, w_sph0[PB-3 -: RB]};
                        if (w_quad[0]) begin
                            n_addr = ROM_TOP - n_addr;
                        end
                        n_pol  = !w_quad[1];
                        n_kind = cdwg_pkg::KIND_SINE;
                        if (w_idx_inc >= {1'b0, w_len}) begin
                            n_sample_index = '0;
                            n_sine_phase   = '0;
                            n_wrap         = 1'b1;
                        end else begin
                            n_sample_index = w_idx_inc[cdwg_pkg::LEN_W-1:0];
                            n_sine_phase   = w_ssum[PB-1:0];
                        end
                    end
                end
                default: ;  // unused mode: zero result, state held
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp         <= '0;
            r_saw_pol      <= 1'b0;
            r_sample_index <= '0;
            r_sine_phase   <= '0;
        end else if (w_accept) begin
            r_ramp         <= n_ramp;
            r_saw_pol      <= n_saw_pol;
            r_sample_index <= n_sample_index;
            r_sine_phase   <= n_sine_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_kind <= n_kind;
            r_s1_pol  <= n_pol;
            r_s1_wrap <= n_wrap;
            r_s1_addr <= n_addr;
            r_s1_ramp <= n_ramp;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: sine table read, ramp product, burst window
    // ------------------------------------------------------------------
    logic [cdwg_pkg::ROM_W-1:0] w_rom_tab [0:ROM_DEPTH-1];

    for (genvar g = 0; g < ROM_DEPTH; g++) begin : g_rom
        assign w_rom_tab[g] = cdwg_pkg::rom_value(g, RB);
    end

    logic [PB+cdwg_pkg::DUTY_W-1:0] w_saw_prod;
    logic [BURST_W-1:0]             w_burst;
    logic                           w_in_burst;
    logic [cdwg_pkg::DUTY_W-1:0]    n_s2_duty;

    cdwg_pkg::t_kind                r_s2_kind;
    logic                           r_s2_pol;
    logic                           r_s2_wrap;
    logic [cdwg_pkg::DUTY_W-1:0]    r_s2_duty;
    logic [cdwg_pkg::ROM_W-1:0]     r_rom;

    always_comb begin
        w_saw_prod = (PB+cdwg_pkg::DUTY_W)'(r_full) * (PB+cdwg_pkg::DUTY_W)'(r_s1_ramp);
        w_burst    = BURST_W'(r_phase_step) * BURST_W'(cdwg_pkg::BURST_MULT);
        // window is the lesser of 60 steps and a quarter period
        w_in_burst = (r_s1_ramp[PB-1 -: 2] == 2'b00) && (BURST_W'(r_s1_ramp) < w_burst);
        case (r_s1_kind)
            cdwg_pkg::KIND_SAW:   n_s2_duty = w_saw_prod[PB +: cdwg_pkg::DUTY_W];
            cdwg_pkg::KIND_LAYER: n_s2_duty = w_in_burst ? r_full : '0;
            default:              n_s2_duty = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv2) begin
            r_s2_kind <= r_s1_kind;
            r_s2_pol  <= r_s1_pol;
            r_s2_wrap <= r_s1_wrap;
            r_s2_duty <= n_s2_duty;
            r_rom     <= w_rom_tab[r_s1_addr];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sine magnitude and output register
    // ------------------------------------------------------------------
    logic [cdwg_pkg::ROM_W+cdwg_pkg::DUTY_W-1:0] w_sine_prod;
    logic [cdwg_pkg::DUTY_W-1:0]                 n_out_duty;
    logic [cdwg_pkg::DUTY_W-1:0]                 r_out_duty;
    logic                                        r_out_pol;
    logic                                        r_out_wrap;

    always_comb begin
        w_sine_prod = (cdwg_pkg::ROM_W+cdwg_pkg::DUTY_W)'(r_full) *
                      (cdwg_pkg::ROM_W+cdwg_pkg::DUTY_W)'(r_rom);
        n_out_duty  = (r_s2_kind == cdwg_pkg::KIND_SINE) ?
                      w_sine_prod[30 +: cdwg_pkg::DUTY_W] : r_s2_duty;
    end

    always_ff @(posedge i_clk) begin
        if (w_advo) begin
            r_out_duty <= n_out_duty;
            r_out_pol  <= r_s2_pol;
            r_out_wrap <= r_s2_wrap;
        end
    end

    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = {6'b0, r_out_wrap, r_out_pol, r_out_duty};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_v1 && r_v2 && r_vo))
        else $error("input stalled while a pipeline stage is empty");

    a_duty_within_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:0] <= r_full))
        else $error("duty above full scale");

    a_sine_wrap_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_s1_kind != cdwg_pkg::KIND_SINE || !r_s1_wrap ||
                      (r_sine_phase == '0 && r_sample_index == '0)))
        else $error("sine wrap left phase or index set");

    a_sine_ramp_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_s1_kind != cdwg_pkg::KIND_SINE || r_ramp == '0))
        else $error("ramp phase not cleared in sine mode");

endmodule
